### rtl/core/matrix_determinant_invertibility_core_defines.svh
// ----------------------------------------------------------------------------
// matrix_determinant_invertibility_core_defines
// Assertion macros shared by the determinant core.
// ----------------------------------------------------------------------------
`ifndef MATRIX_DETERMINANT_INVERTIBILITY_CORE_DEFINES_SVH
`define MATRIX_DETERMINANT_INVERTIBILITY_CORE_DEFINES_SVH

// Implication checked at every clock edge outside reset.
`define MDI_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication checked at every clock edge outside reset.
`define MDI_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/core/mdi_pkg.sv
// ----------------------------------------------------------------------------
// mdi_pkg
// Types and constants shared by the determinant core.
// ----------------------------------------------------------------------------
package mdi_pkg;
    localparam int unsigned DefMaxOrder = 8;
    localparam int unsigned DataW       = 32;
    localparam int unsigned OrderW      = 4;
    localparam logic [OrderW-1:0] OrderReset = 4'd2;

    typedef logic [DataW-1:0] t_word;

    // Status handed from the engine to the top level.
    typedef struct packed {
        logic busy;
        logic done;
    } t_eng_status;
endpackage

### rtl/core/mdi_stream_if.sv
// ----------------------------------------------------------------------------
// mdi_stream_if
// Valid/ready channel with a generic payload.
// ----------------------------------------------------------------------------
interface mdi_stream_if #(
    parameter type t_payload = logic [31:0]
);
    logic     valid;
    logic     ready;
    t_payload payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

### rtl/core/mdi_engine.sv
// ----------------------------------------------------------------------------
// mdi_engine
// Subset recurrence over columns: a memory of partial sums indexed by the
// set of used columns, updated by one multiply-add at a time (S_COL, S_MUL, S_WR).
// ----------------------------------------------------------------------------
module mdi_engine #(
    parameter int unsigned MaxOrder = mdi_pkg::DefMaxOrder,
    parameter int unsigned IdxW     = $clog2(MaxOrder),
    parameter int unsigned AddrW    = $clog2(MaxOrder * MaxOrder)
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_start,
    input  logic [IdxW:0]         i_n,
    output logic [AddrW-1:0]      o_mat_addr,
    input  mdi_pkg::t_word        i_mat_data,
    output mdi_pkg::t_word        o_det,
    output mdi_pkg::t_eng_status  o_status
);
    import mdi_pkg::*;

    localparam int unsigned MaskW = MaxOrder;
    localparam int unsigned Depth = 1 << MaxOrder;

    typedef enum logic [7:0] {
        S_IDLE  = 8'b0000_0001,
        S_CLEAR = 8'b0000_0010,
        S_RDACC = 8'b0000_0100,
        S_ACC   = 8'b0000_1000,
        S_COL   = 8'b0001_0000,
        S_MUL   = 8'b0010_0000,
        S_WR    = 8'b0100_0000,
        S_FIN   = 8'b1000_0000
    } t_state;

    t_state           r_state, n_state;
    t_word            r_acc_mem [Depth];

    logic [MaskW-1:0] r_mask, n_mask;
    logic [IdxW:0]    r_col, n_col;
    logic [IdxW:0]    r_row, n_row;
    t_word            r_acc, n_acc;
    logic [MaskW-1:0] r_tgt, n_tgt;
    logic             r_neg, n_neg;
    t_word            r_term, n_term;
    logic [MaskW-1:0] w_full;
    logic [MaskW-1:0] w_col_bit;

    // Memory ports.
    logic             w_we, w_re;
    logic [MaskW-1:0] w_waddr, w_raddr;
    t_word            w_wdata, r_rdata;

    assign w_full     = MaskW'((1 << i_n) - 1);
    assign w_col_bit  = MaskW'(1 << r_col);
    assign o_mat_addr = AddrW'(r_row) * AddrW'(i_n) + AddrW'(r_col);

    always_ff @(posedge i_clk) begin
        if (w_we) r_acc_mem[w_waddr] <= w_wdata;
        if (w_re) r_rdata <= r_acc_mem[w_raddr];
    end

    always_comb begin
        n_state = r_state;
        n_mask  = r_mask;
        n_col   = r_col;
        n_row   = r_row;
        n_acc   = r_acc;
        n_tgt   = r_tgt;
        n_neg   = r_neg;
        n_term  = r_term;
        w_we    = 1'b0;
        w_re    = 1'b0;
        w_waddr = r_mask;
        w_wdata = '0;
        w_raddr = r_mask;
        unique case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    n_state = S_CLEAR;
                    n_mask  = '0;
                end
            end
            S_CLEAR: begin
                w_we    = 1'b1;
                w_wdata = (r_mask == '0) ? t_word'(1) : '0;
                if (r_mask == w_full) begin
                    n_state = S_RDACC;
                    n_mask  = '0;
                end else begin
                    n_mask = r_mask + 1'b1;
                end
            end
            S_RDACC: begin
                w_re = 1'b1;
                if (r_mask == w_full) n_state = S_FIN;
                else n_state = S_ACC;
            end
            S_ACC: begin
                // A zero partial sum adds nothing to any superset.
                n_acc = r_rdata;
                n_col = '0;
                n_row = (IdxW+1)'($countones(r_mask));
                if (r_rdata == '0) begin
                    n_mask  = r_mask + 1'b1;
                    n_state = S_RDACC;
                end else begin
                    n_state = S_COL;
                end
            end
            S_COL: begin
                if (r_col >= i_n) begin
                    n_mask  = r_mask + 1'b1;
                    n_state = S_RDACC;
                end else if (r_mask[r_col[IdxW-1:0]]) begin
                    n_col = r_col + 1'b1;
                end else begin
                    // The matrix word for this row and column is read in parallel.
                    w_re    = 1'b1;
                    w_raddr = r_mask | w_col_bit;
                    n_tgt   = r_mask | w_col_bit;
                    n_neg   = ^(r_mask >> (r_col + 1'b1));
                    n_state = S_MUL;
                end
            end
            S_MUL: begin
                n_term  = r_acc * i_mat_data;
                n_state = S_WR;
            end
            S_WR: begin
                w_we    = 1'b1;
                w_waddr = r_tgt;
                w_wdata = r_neg ? r_rdata - r_term : r_rdata + r_term;
                n_col   = r_col + 1'b1;
                n_state = S_COL;
            end
            S_FIN: begin
                n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
        r_mask <= n_mask;
        r_col  <= n_col;
        r_row  <= n_row;
        r_acc  <= n_acc;
        r_tgt  <= n_tgt;
        r_neg  <= n_neg;
        r_term <= n_term;
    end

    // In the final state the read data holds the sum for the full column set.
    assign o_det    = r_rdata;
    assign o_status = '{busy: (r_state != S_IDLE), done: (r_state == S_FIN)};
endmodule

### rtl/core/matrix_determinant_invertibility_core.sv
// ----------------------------------------------------------------------------
// matrix_determinant_invertibility_core
// Streams in a square matrix and returns its determinant modulo 2^32.
// ----------------------------------------------------------------------------
// Usage: write the order (2..MaxOrder, out-of-range values are clamped) while
// the block is idle, then send order*order elements row-major on the input
// channel, at most one transfer per cycle. A write of the order discards any
// partial load. After the last element the input drops ready; the engine
// clears a partial-sum memory and walks every column subset, doing one
// multiply-add at a time. One result transfer (det_value, invertible)
// follows from an output register.
// One matrix is handled at a time: the next matrix does not load while
// the engine works.
// While the receiver stalls, the next matrix may load up to but not
// including its last element, which waits until the result is taken.
// Reset sets the order to 2 and clears the load count; the matrix and
// partial-sum memories hold no reset value.
// ----------------------------------------------------------------------------
module matrix_determinant_invertibility_core #(
    parameter int unsigned MaxOrder = mdi_pkg::DefMaxOrder
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [mdi_pkg::OrderW-1:0]    i_cfg_wdata,
    mdi_stream_if.sink                    in_if,
    mdi_stream_if.source                  out_if
);
    import mdi_pkg::*;
`include "matrix_determinant_invertibility_core_defines.svh"

    localparam int unsigned IdxW  = $clog2(MaxOrder);
    localparam int unsigned AddrW = $clog2(MaxOrder * MaxOrder);

    logic [OrderW-1:0] r_order;
    logic [IdxW:0]     w_n;
    logic [AddrW:0]    r_cnt;
    logic [AddrW:0]    w_total;
    t_word             r_mat [MaxOrder * MaxOrder];
    t_word             r_mat_q;
    logic [AddrW-1:0]  w_mat_addr;
    logic              w_in_xfer, w_last, w_hold_last, r_start, r_out_vld;
    t_word             w_det, r_det;
    t_eng_status       w_st;

    assign w_n = (r_order < 2) ? (IdxW+1)'(2) :
                 (int'(r_order) > int'(MaxOrder)) ? (IdxW+1)'(MaxOrder) : (IdxW+1)'(r_order);
    assign w_total   = (AddrW+1)'(int'(w_n) * int'(w_n));
    // The last element may not start the engine while a result still waits.
    assign w_hold_last = r_out_vld && (r_cnt == w_total - 1'b1);
    assign in_if.ready = !w_st.busy && !r_start && !w_hold_last;
    assign w_in_xfer = in_if.valid && in_if.ready;
    assign w_last    = w_in_xfer && (r_cnt == w_total - 1'b1);

    always_ff @(posedge i_clk) begin
        if (w_in_xfer) r_mat[r_cnt[AddrW-1:0]] <= in_if.payload;
        r_mat_q <= r_mat[w_mat_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_order   <= OrderReset;
            r_cnt     <= '0;
            r_start   <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            r_start <= w_last;
            if (i_cfg_we) begin
                r_order <= i_cfg_wdata;
                r_cnt   <= '0;
            end else if (w_last) r_cnt <= '0;
            else if (w_in_xfer) r_cnt <= r_cnt + 1'b1;
            if (w_st.done) r_out_vld <= 1'b1;
            else if (out_if.ready) r_out_vld <= 1'b0;
        end
        if (w_st.done) r_det <= w_det;
    end

    mdi_engine #(.MaxOrder(MaxOrder)) u_engine (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (r_start),
        .i_n        (w_n),
        .o_mat_addr (w_mat_addr),
        .i_mat_data (r_mat_q),
        .o_det      (w_det),
        .o_status   (w_st)
    );

    assign out_if.valid              = r_out_vld;
    assign out_if.payload.det_value  = r_det;
    assign out_if.payload.invertible = (r_det != '0);

    `MDI_ASSERT_IMP(a_no_load_busy, i_clk, i_rst_n, w_st.busy, !in_if.ready, "load during work")
    `MDI_ASSERT_NXT(a_start_busy, i_clk, i_rst_n, r_start, w_st.busy, "engine did not start")
    `MDI_ASSERT_IMP(a_cnt_range, i_clk, i_rst_n, 1'b1, r_cnt < w_total + 1'b1, "count overrun")
    `MDI_ASSERT_NXT(a_out_hold, i_clk, i_rst_n, out_if.valid && !out_if.ready, out_if.valid && $stable(r_det), "result changed while stalled")
endmodule

### test/mdi_tb_if.sv
// ----------------------------------------------------------------------------
// mdi_tb_if
// Result payload type used by the determinant testbench channels.
// ----------------------------------------------------------------------------
package mdi_tb_pkg;
    typedef struct packed {
        logic [31:0] det_value;
        logic        invertible;
    } t_det_result;
endpackage

### test/matrix_determinant_invertibility_core_tb.sv
// ----------------------------------------------------------------------------
// matrix_determinant_invertibility_core_tb
// Loads matrices of every order with directed and random elements under
// random idling and back-pressure, and checks each determinant and
// invertible flag against a subset-recurrence predictor.
// ----------------------------------------------------------------------------
class det_scoreboard;
    logic [31:0] matrix [64];
    int unsigned order_eff;
    int unsigned fill_count;
    logic [32:0] pending [$];
    int unsigned fail_count;

    function void set_order(logic [3:0] value);
        if (value < 2) begin
            order_eff = 2;
        end else if (value > 8) begin
            order_eff = 8;
        end else begin
            order_eff = value;
        end
        fill_count = 0;
    endfunction

    function logic [31:0] determinant();
        logic [31:0] partial [256];
        logic [31:0] term;
        int unsigned full_set;
        int unsigned row;
        full_set = (1 << order_eff) - 1;
        foreach (partial[k]) partial[k] = '0;
        partial[0] = 32'd1;
        for (int unsigned m = 0; m < full_set; m++) begin
            if (partial[m] != 0) begin
                row = $countones(m);
                for (int unsigned c = 0; c < order_eff; c++) begin
                    if (!m[c]) begin
                        term = partial[m] * matrix[row * order_eff + c];
                        // Sign flips for each used column to the right.
                        if ($countones(m >> (c + 1)) % 2)
                            partial[m | (1 << c)] -= term;
                        else
                            partial[m | (1 << c)] += term;
                    end
                end
            end
        end
        return partial[full_set];
    endfunction

    function void note_element(logic [31:0] element);
        logic [31:0] det;
        matrix[fill_count] = element;
        fill_count++;
        if (fill_count == order_eff * order_eff) begin
            fill_count = 0;
            det = determinant();
            pending.push_back({det, det != 0});
        end
    endfunction

    function void check_result(logic [31:0] det_value, logic invertible);
        logic [32:0] want;
        if (pending.size() == 0) begin
            $error("unexpected result det_value=%0h", det_value);
            fail_count++;
            return;
        end
        want = pending.pop_front();
        if (want[32:1] !== det_value) begin
            $error("det_value expected %0h actual %0h", want[32:1], det_value);
            fail_count++;
        end
        if (want[0] !== invertible) begin
            $error("invertible expected %0b actual %0b", want[0], invertible);
            fail_count++;
        end
    endfunction
endclass

module matrix_determinant_invertibility_core_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import mdi_tb_pkg::*;

    logic       i_clk = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       i_cfg_we = 1'b0;
    logic [3:0] i_cfg_wdata = '0;
    logic       hold_off = 1'b0;
    int unsigned idle_cycles = 0;
    int unsigned rx_wait = 0;
    int unsigned rx_draw = 0;

    mdi_stream_if #(.t_payload(logic [31:0])) in_if ();
    mdi_stream_if #(.t_payload(t_det_result)) out_if ();

    det_scoreboard det_board = new();

    matrix_determinant_invertibility_core dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cfg_we(i_cfg_we),
        .i_cfg_wdata(i_cfg_wdata), .in_if(in_if), .out_if(out_if)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Valid stays high across back-to-back elements and drops during gaps.
    task automatic send_element(logic [31:0] element);
        int unsigned gap;
        gap = $urandom_range(0, 12);
        if (gap != 0) begin
            in_if.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_if.valid <= 1'b1;
        in_if.payload <= element;
        do @(posedge i_clk); while (!in_if.ready);
        det_board.note_element(element);
    endtask

    task automatic wait_drained();
        in_if.valid <= 1'b0;
        while (det_board.pending.size() != 0) @(posedge i_clk);
        repeat (2) @(posedge i_clk);
    endtask

    task automatic write_order(logic [3:0] value);
        in_if.valid <= 1'b0;
        i_cfg_we <= 1'b1;
        i_cfg_wdata <= value;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        det_board.set_order(value);
    endtask

    function automatic logic [31:0] random_element(int unsigned style);
        case (style)
            0: return $urandom_range(0, 6) - 3;
            1: return $urandom_range(0, 1) ? 32'h7fff_ffff : 32'h8000_0000;
            default: return $urandom();
        endcase
    endfunction

    // Receiver: a random wait before each result, plus one long hold-off.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            out_if.ready <= 1'b0;
            rx_wait <= 0;
        end else begin
            if (out_if.valid && out_if.ready) begin
                det_board.check_result(out_if.payload.det_value,
                                       out_if.payload.invertible);
                rx_draw = $urandom_range(0, 12);
                rx_wait <= rx_draw;
                out_if.ready <= (rx_draw == 0) && !hold_off;
            end else if (rx_wait != 0) begin
                rx_wait <= rx_wait - 1;
                out_if.ready <= (rx_wait == 1) && !hold_off;
            end else begin
                out_if.ready <= !hold_off;
            end
        end
    end

    // Watchdog over cycles with no transfer.
    always @(posedge i_clk) begin
        if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready) || !i_rst_n)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > 30000) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    initial begin
        int unsigned sent;
        logic [3:0] order_pick;
        in_if.valid = 1'b0;
        in_if.payload = '0;
        det_board.set_order(4'd2);
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: identity, extremes, singular and wrapping 2x2 cases.
        send_element(32'd1); send_element(32'd0);
        send_element(32'd0); send_element(32'd1);
        send_element(32'h8000_0000); send_element(32'h7fff_ffff);
        send_element(32'h7fff_ffff); send_element(32'h8000_0000);
        send_element(32'hffff_ffff); send_element(32'hffff_ffff);
        send_element(32'hffff_ffff); send_element(32'hffff_ffff);
        send_element(32'h0001_0000); send_element(32'd0);
        send_element(32'd0); send_element(32'h0001_0000);
        // Partial load then an order write that discards it.
        send_element(32'd5);
        wait_drained();
        write_order(4'd0);
        send_element(32'd3); send_element(32'd1);
        send_element(32'd2); send_element(32'd4);
        wait_drained();

        // Long receiver hold-off while the sender keeps offering.
        write_order(4'd3);
        fork
            begin
                hold_off <= 1'b1;
                repeat (2000) @(posedge i_clk);
                hold_off <= 1'b0;
            end
            repeat (45) send_element(random_element($urandom_range(0, 2)));
        join
        wait_drained();

        sent = 0;
        while (sent < 1750) begin
            order_pick = $urandom_range(0, 15);
            // Most matrices are small; the largest orders are kept rare.
            if (order_pick > 5 && $urandom_range(0, 5) != 0)
                order_pick = $urandom_range(2, 4);
            write_order(order_pick);
            repeat ($urandom_range(1, 4) * det_board.order_eff * det_board.order_eff) begin
                send_element(random_element($urandom_range(0, 2)));
                sent++;
            end
            if ($urandom_range(0, 7) == 0) begin
                // Broken load: a few extra elements, then the order write drops them.
                repeat ($urandom_range(1, 3)) send_element($urandom());
            end
            wait_drained();
        end
        write_order(4'd15);
        repeat (64) send_element(random_element(2));
        wait_drained();
        write_order(4'd2);
        wait_drained();
        if (det_board.fail_count == 0 && det_board.pending.size() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end
endmodule

### filelist.f
+incdir+rtl/core
rtl/core/mdi_pkg.sv
rtl/core/mdi_stream_if.sv
rtl/core/mdi_engine.sv
rtl/core/matrix_determinant_invertibility_core.sv
test/mdi_tb_if.sv
test/matrix_determinant_invertibility_core_tb.sv
